/* rtl/core/ctpt_pkg.sv */
// Shared types and region codes for the closest-point-on-triangle unit.
`default_nettype none

package ctpt_pkg;

    typedef logic [2:0] region_t;

    localparam region_t REG_VERT_A = 3'd0;
    localparam region_t REG_VERT_B = 3'd1;
    localparam region_t REG_EDGE_AB = 3'd2;
    localparam region_t REG_VERT_C = 3'd3;
    localparam region_t REG_EDGE_AC = 3'd4;
    localparam region_t REG_EDGE_BC = 3'd5;
    localparam region_t REG_DEGEN = 3'd6;
    localparam region_t REG_FACE = 3'd7;

endpackage

`default_nettype wire

/* rtl/core/ctpt_divider.sv */
// Pipelined restoring divider that returns the floor of a signed quotient.
`default_nettype none

module ctpt_divider #(
    parameter int NUM_W = 91,
    parameter int DEN_W = 75,
    parameter int QUO_W = 18
) (
    input  wire logic                     clk,
    input  wire logic signed [NUM_W-1:0]  num,
    input  wire logic signed [DEN_W-1:0]  den,
    output logic signed [QUO_W:0]         quo
);

    localparam int HI_W = NUM_W - QUO_W;

    // Magnitudes and the sign of the true quotient.
    logic [NUM_W-1:0] un_reg;
    logic [DEN_W-1:0] ud_reg;
    logic             neg_reg;

    // One quotient bit is settled per stage.
    logic [DEN_W-1:0] rem_reg  [QUO_W];
    logic [QUO_W-1:0] low_reg  [QUO_W];
    logic [QUO_W-1:0] q_reg    [QUO_W];
    logic [DEN_W-1:0] dv_reg   [QUO_W];
    logic             sg_reg   [QUO_W];

    logic [DEN_W-1:0] rem_next [QUO_W];
    logic [QUO_W-1:0] low_next [QUO_W];
    logic [QUO_W-1:0] q_next   [QUO_W];

    logic signed [QUO_W:0] quo_reg;
    logic signed [QUO_W:0] quo_next;

    always_comb
    begin
        logic [DEN_W-1:0] prev_rem;
        logic [QUO_W-1:0] prev_low;
        logic [QUO_W-1:0] prev_q;
        logic [DEN_W-1:0] prev_dv;
        logic [DEN_W:0]   trial;
        logic             fits;
        for (int i = 0; i < QUO_W; i++)
        begin
            if (i == 0)
            begin
                prev_rem = {{(DEN_W - HI_W){1'b0}}, un_reg[NUM_W-1:QUO_W]};
                prev_low = un_reg[QUO_W-1:0];
                prev_q   = '0;
                prev_dv  = ud_reg;
            end
            else
            begin
                prev_rem = rem_reg[i-1];
                prev_low = low_reg[i-1];
                prev_q   = q_reg[i-1];
                prev_dv  = dv_reg[i-1];
            end
            trial       = {prev_rem, prev_low[QUO_W-1]};
            fits        = (trial >= {1'b0, prev_dv});
            rem_next[i] = fits ? DEN_W'(trial - {1'b0, prev_dv}) : trial[DEN_W-1:0];
            low_next[i] = {prev_low[QUO_W-2:0], 1'b0};
            q_next[i]   = {prev_q[QUO_W-2:0], fits};
        end
    end

    // Floor correction: a negative quotient with a remainder steps down by one.
    always_comb
    begin
        logic [QUO_W:0] q_ext;
        q_ext = {1'b0, q_reg[QUO_W-1]};
        if (sg_reg[QUO_W-1])
        begin
            quo_next = $signed(~q_ext + {{QUO_W{1'b0}}, (rem_reg[QUO_W-1] == '0)});
        end
        else
        begin
            quo_next = $signed(q_ext);
        end
    end

    always_ff @(posedge clk)
    begin
        un_reg  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        ud_reg  <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        neg_reg <= num[NUM_W-1] ^ den[DEN_W-1];
        for (int i = 0; i < QUO_W; i++)
        begin
            rem_reg[i] <= rem_next[i];
            low_reg[i] <= low_next[i];
            q_reg[i]   <= q_next[i];
            if (i == 0)
            begin
                dv_reg[i] <= ud_reg;
                sg_reg[i] <= neg_reg;
            end
            else
            begin
                dv_reg[i] <= dv_reg[i-1];
                sg_reg[i] <= sg_reg[i-1];
            end
        end
        quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

/* rtl/core/closest_point_on_triangle_unit.sv */
// Top level of the pipelined closest-point-on-triangle unit.
`default_nettype none

// Usage: drive the query point and the three vertices and raise start for one
// cycle per item. An item is taken at every rising edge where start is high and
// busy is low. The unit never stalls, so busy is always low and a new item can
// enter in every cycle.
// Each result appears on closest_x/y/z and region for exactly one cycle with
// done high, and is taken at the edge that ends that cycle.
// Results leave in the order the items came in.
// The latency is set by the arithmetic chain: six stages of dot products,
// barycentric terms and region selection, two stages of split multiplies for
// the projection numerator, a restoring divider that settles one quotient bit
// per stage (COORD_WIDTH + 2 stages plus entry and floor correction), and one
// stage that adds the base vertex and clamps.
// The receiver cannot hold results off; done is a strobe and must be sampled.
// Reset clears only the valid bits, so no stale strobe leaves the unit after
// reset; items in flight at reset are dropped.
module closest_point_on_triangle_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_WIDTH-1:0] point_x,
    input  wire logic signed [COORD_WIDTH-1:0] point_y,
    input  wire logic signed [COORD_WIDTH-1:0] point_z,
    input  wire logic signed [COORD_WIDTH-1:0] vert_a_x,
    input  wire logic signed [COORD_WIDTH-1:0] vert_a_y,
    input  wire logic signed [COORD_WIDTH-1:0] vert_a_z,
    input  wire logic signed [COORD_WIDTH-1:0] vert_b_x,
    input  wire logic signed [COORD_WIDTH-1:0] vert_b_y,
    input  wire logic signed [COORD_WIDTH-1:0] vert_b_z,
    input  wire logic signed [COORD_WIDTH-1:0] vert_c_x,
    input  wire logic signed [COORD_WIDTH-1:0] vert_c_y,
    input  wire logic signed [COORD_WIDTH-1:0] vert_c_z,
    output logic                               done,
    output logic signed [COORD_WIDTH-1:0]      closest_x,
    output logic signed [COORD_WIDTH-1:0]      closest_y,
    output logic signed [COORD_WIDTH-1:0]      closest_z,
    output ctpt_pkg::region_t                  region
);

    localparam int W    = COORD_WIDTH;
    localparam int DIFW = W + 1;          // vertex differences
    localparam int PRDW = 2 * DIFW;       // one coordinate product
    localparam int DOTW = PRDW + 2;       // dot products d1..d6
    localparam int EW   = DOTW + 1;       // differences of dot products
    localparam int EBCW = DOTW + 2;       // bc edge denominator
    localparam int MW   = 2 * DOTW;       // products of dot products
    localparam int BARW = MW + 1;         // va, vb, vc
    localparam int DENW = BARW + 2;       // face denominator
    localparam int CW   = BARW;           // projection coefficient
    localparam int LOW  = CW / 2;         // low half of a split coefficient
    localparam int HIW  = CW - LOW;       // high half
    localparam int PPW  = DIFW + HIW + 1; // one partial product
    localparam int NUMW = DIFW + CW + 1;  // projection numerator
    localparam int QW   = W + 2;          // quotient magnitude bits
    localparam int DLAT = QW + 2;         // divider latency
    localparam int SUMW = QW + 2;         // base plus quotient
    localparam int TOT  = 9 + DLAT;       // number of valid stages
    localparam int LAT  = TOT;            // accept edge to result edge

    localparam logic signed [SUMW-1:0] SAT_HI = {{(SUMW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [SUMW-1:0] SAT_LO = {{(SUMW - W + 1){1'b1}}, {(W - 1){1'b0}}};

    // Triangle geometry that rides along until the region is chosen.
    typedef struct packed {
        logic [2:0][W-1:0]    a;
        logic [2:0][W-1:0]    b;
        logic [2:0][W-1:0]    c;
        logic [2:0][DIFW-1:0] ab;
        logic [2:0][DIFW-1:0] ac;
        logic [2:0][DIFW-1:0] bc;
    } geo_t;

    // Region tests that depend only on the dot products.
    typedef struct packed {
        logic fa;   // vertex a
        logic fb;   // vertex b
        logic fc;   // vertex c
        logic cab;  // dot-product part of the ab edge test
        logic cac;  // dot-product part of the ac edge test
    } flags_t;

    logic accept;
    logic [TOT-1:0] v_reg;

    logic signed [W-1:0] in_p [3];
    logic signed [W-1:0] in_a [3];
    logic signed [W-1:0] in_b [3];
    logic signed [W-1:0] in_c [3];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign in_p[0] = point_x;
    assign in_p[1] = point_y;
    assign in_p[2] = point_z;
    assign in_a[0] = vert_a_x;
    assign in_a[1] = vert_a_y;
    assign in_a[2] = vert_a_z;
    assign in_b[0] = vert_b_x;
    assign in_b[1] = vert_b_y;
    assign in_b[2] = vert_b_z;
    assign in_c[0] = vert_c_x;
    assign in_c[1] = vert_c_y;
    assign in_c[2] = vert_c_z;

    // Valid bits travel with the data through every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[TOT-2:0], accept};
        end
    end

    // Stage 1: edge vectors and the query point relative to each vertex.
    geo_t                   s1_geo_reg;
    logic signed [DIFW-1:0] s1_pv_reg [3][3];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            s1_geo_reg.a[k]  <= in_a[k];
            s1_geo_reg.b[k]  <= in_b[k];
            s1_geo_reg.c[k]  <= in_c[k];
            s1_geo_reg.ab[k] <= DIFW'(in_b[k]) - DIFW'(in_a[k]);
            s1_geo_reg.ac[k] <= DIFW'(in_c[k]) - DIFW'(in_a[k]);
            s1_geo_reg.bc[k] <= DIFW'(in_c[k]) - DIFW'(in_b[k]);
            s1_pv_reg[0][k]  <= DIFW'(in_p[k]) - DIFW'(in_a[k]);
            s1_pv_reg[1][k]  <= DIFW'(in_p[k]) - DIFW'(in_b[k]);
            s1_pv_reg[2][k]  <= DIFW'(in_p[k]) - DIFW'(in_c[k]);
        end
    end

    // Stage 2: coordinate products. Even entries pair with ab, odd with ac.
    geo_t                   s2_geo_reg;
    logic signed [PRDW-1:0] s2_pr_reg [6][3];

    always_ff @(posedge clk)
    begin
        s2_geo_reg <= s1_geo_reg;
        for (int v = 0; v < 3; v++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s2_pr_reg[2*v][k]   <= $signed(s1_geo_reg.ab[k]) * s1_pv_reg[v][k];
                s2_pr_reg[2*v+1][k] <= $signed(s1_geo_reg.ac[k]) * s1_pv_reg[v][k];
            end
        end
    end

    // Stage 3: the six dot products d1..d6 (index 0..5).
    geo_t                   s3_geo_reg;
    logic signed [DOTW-1:0] s3_d_reg [6];

    always_ff @(posedge clk)
    begin
        s3_geo_reg <= s2_geo_reg;
        for (int j = 0; j < 6; j++)
        begin
            s3_d_reg[j] <= DOTW'(s2_pr_reg[j][0]) + DOTW'(s2_pr_reg[j][1])
                         + DOTW'(s2_pr_reg[j][2]);
        end
    end

    // Stage 4: cross products of dot products and the simple vertex tests.
    geo_t                   s4_geo_reg;
    flags_t                 s4_flags_reg;
    logic signed [MW-1:0]   s4_m_reg [6];
    logic signed [EW-1:0]   s4_e1_reg;
    logic signed [EW-1:0]   s4_e2_reg;
    logic signed [EW-1:0]   s4_dab_reg;
    logic signed [EW-1:0]   s4_dac_reg;
    logic signed [DOTW-1:0] s4_d1_reg;
    logic signed [DOTW-1:0] s4_d2_reg;

    always_ff @(posedge clk)
    begin
        s4_geo_reg      <= s3_geo_reg;
        s4_m_reg[0]     <= s3_d_reg[0] * s3_d_reg[3];
        s4_m_reg[1]     <= s3_d_reg[2] * s3_d_reg[1];
        s4_m_reg[2]     <= s3_d_reg[4] * s3_d_reg[1];
        s4_m_reg[3]     <= s3_d_reg[0] * s3_d_reg[5];
        s4_m_reg[4]     <= s3_d_reg[2] * s3_d_reg[5];
        s4_m_reg[5]     <= s3_d_reg[4] * s3_d_reg[3];
        s4_e1_reg       <= EW'(s3_d_reg[3]) - EW'(s3_d_reg[2]);
        s4_e2_reg       <= EW'(s3_d_reg[4]) - EW'(s3_d_reg[5]);
        s4_dab_reg      <= EW'(s3_d_reg[0]) - EW'(s3_d_reg[2]);
        s4_dac_reg      <= EW'(s3_d_reg[1]) - EW'(s3_d_reg[5]);
        s4_d1_reg       <= s3_d_reg[0];
        s4_d2_reg       <= s3_d_reg[1];
        s4_flags_reg.fa <= (s3_d_reg[0] <= 0) && (s3_d_reg[1] <= 0);
        s4_flags_reg.fb <= (s3_d_reg[2] >= 0) && (s3_d_reg[3] <= s3_d_reg[2]);
        s4_flags_reg.fc <= (s3_d_reg[5] >= 0) && (s3_d_reg[4] <= s3_d_reg[5]);
        s4_flags_reg.cab <= (s3_d_reg[0] >= 0) && (s3_d_reg[2] <= 0);
        s4_flags_reg.cac <= (s3_d_reg[1] >= 0) && (s3_d_reg[5] <= 0);
    end

    // Stage 5: barycentric terms va, vb, vc and the bc edge denominator.
    geo_t                   s5_geo_reg;
    flags_t                 s5_flags_reg;
    logic signed [BARW-1:0] s5_va_reg;
    logic signed [BARW-1:0] s5_vb_reg;
    logic signed [BARW-1:0] s5_vc_reg;
    logic signed [EW-1:0]   s5_e1_reg;
    logic signed [EW-1:0]   s5_e2_reg;
    logic signed [EW-1:0]   s5_dab_reg;
    logic signed [EW-1:0]   s5_dac_reg;
    logic signed [EBCW-1:0] s5_dbc_reg;
    logic signed [DOTW-1:0] s5_d1_reg;
    logic signed [DOTW-1:0] s5_d2_reg;

    always_ff @(posedge clk)
    begin
        s5_geo_reg   <= s4_geo_reg;
        s5_flags_reg <= s4_flags_reg;
        s5_vc_reg    <= BARW'(s4_m_reg[0]) - BARW'(s4_m_reg[1]);
        s5_vb_reg    <= BARW'(s4_m_reg[2]) - BARW'(s4_m_reg[3]);
        s5_va_reg    <= BARW'(s4_m_reg[4]) - BARW'(s4_m_reg[5]);
        s5_dbc_reg   <= EBCW'(s4_e1_reg) + EBCW'(s4_e2_reg);
        s5_e1_reg    <= s4_e1_reg;
        s5_e2_reg    <= s4_e2_reg;
        s5_dab_reg   <= s4_dab_reg;
        s5_dac_reg   <= s4_dac_reg;
        s5_d1_reg    <= s4_d1_reg;
        s5_d2_reg    <= s4_d2_reg;
    end

    // Stage 6: region choice in the standard test order. Every region is cast as
    // base + floor((dir1 * coef1 + dir2 * coef2) / den); vertex and degenerate
    // results use zero coefficients over a unit denominator.
    ctpt_pkg::region_t      sel_region;
    logic signed [W-1:0]    sel_base [3];
    logic signed [DIFW-1:0] sel_dir1 [3];
    logic signed [DIFW-1:0] sel_dir2 [3];
    logic signed [CW-1:0]   sel_coef1;
    logic signed [CW-1:0]   sel_coef2;
    logic signed [DENW-1:0] sel_den;
    logic signed [DENW-1:0] den_face;

    always_comb
    begin
        den_face = DENW'(s5_va_reg) + DENW'(s5_vb_reg) + DENW'(s5_vc_reg);
        for (int k = 0; k < 3; k++)
        begin
            sel_base[k] = $signed(s5_geo_reg.a[k]);
            sel_dir1[k] = $signed(s5_geo_reg.ab[k]);
            sel_dir2[k] = $signed(s5_geo_reg.ac[k]);
        end
        sel_coef1  = '0;
        sel_coef2  = '0;
        sel_den    = DENW'(1);
        sel_region = ctpt_pkg::REG_FACE;
        priority if (s5_flags_reg.fa)
        begin
            sel_region = ctpt_pkg::REG_VERT_A;
        end
        else if (s5_flags_reg.fb)
        begin
            sel_region = ctpt_pkg::REG_VERT_B;
            for (int k = 0; k < 3; k++)
            begin
                sel_base[k] = $signed(s5_geo_reg.b[k]);
            end
        end
        else if ((s5_vc_reg <= 0) && s5_flags_reg.cab)
        begin
            sel_region = ctpt_pkg::REG_EDGE_AB;
            sel_coef1  = CW'(s5_d1_reg);
            sel_den    = DENW'(s5_dab_reg);
        end
        else if (s5_flags_reg.fc)
        begin
            sel_region = ctpt_pkg::REG_VERT_C;
            for (int k = 0; k < 3; k++)
            begin
                sel_base[k] = $signed(s5_geo_reg.c[k]);
            end
        end
        else if ((s5_vb_reg <= 0) && s5_flags_reg.cac)
        begin
            sel_region = ctpt_pkg::REG_EDGE_AC;
            for (int k = 0; k < 3; k++)
            begin
                sel_dir1[k] = $signed(s5_geo_reg.ac[k]);
            end
            sel_coef1 = CW'(s5_d2_reg);
            sel_den   = DENW'(s5_dac_reg);
        end
        else if ((s5_va_reg <= 0) && (s5_e1_reg >= 0) && (s5_e2_reg >= 0))
        begin
            sel_region = ctpt_pkg::REG_EDGE_BC;
            for (int k = 0; k < 3; k++)
            begin
                sel_base[k] = $signed(s5_geo_reg.b[k]);
                sel_dir1[k] = $signed(s5_geo_reg.bc[k]);
            end
            sel_coef1 = CW'(s5_e1_reg);
            sel_den   = DENW'(s5_dbc_reg);
        end
        else if (den_face == '0)
        begin
            sel_region = ctpt_pkg::REG_DEGEN;
        end
        else
        begin
            sel_coef1 = s5_vb_reg;
            sel_coef2 = s5_vc_reg;
            sel_den   = den_face;
        end
        // A zero-length edge falls back to its start point.
        if (sel_den == '0)
        begin
            sel_coef1 = '0;
            sel_coef2 = '0;
            sel_den   = DENW'(1);
        end
    end

    ctpt_pkg::region_t      s6_region_reg;
    logic signed [W-1:0]    s6_base_reg [3];
    logic signed [DIFW-1:0] s6_dir1_reg [3];
    logic signed [DIFW-1:0] s6_dir2_reg [3];
    logic signed [CW-1:0]   s6_coef1_reg;
    logic signed [CW-1:0]   s6_coef2_reg;
    logic signed [DENW-1:0] s6_den_reg;

    always_ff @(posedge clk)
    begin
        s6_region_reg <= sel_region;
        s6_coef1_reg  <= sel_coef1;
        s6_coef2_reg  <= sel_coef2;
        s6_den_reg    <= sel_den;
        for (int k = 0; k < 3; k++)
        begin
            s6_base_reg[k] <= sel_base[k];
            s6_dir1_reg[k] <= sel_dir1[k];
            s6_dir2_reg[k] <= sel_dir2[k];
        end
    end

    // Stage 7: each coefficient is split in halves so no multiplier grows past
    // the direction width times half the coefficient.
    ctpt_pkg::region_t      s7_region_reg;
    logic signed [W-1:0]    s7_base_reg [3];
    logic signed [DENW-1:0] s7_den_reg;
    logic signed [PPW-1:0]  s7_pp_reg [3][4];

    always_ff @(posedge clk)
    begin
        s7_region_reg <= s6_region_reg;
        s7_den_reg    <= s6_den_reg;
        for (int k = 0; k < 3; k++)
        begin
            s7_base_reg[k]  <= s6_base_reg[k];
            s7_pp_reg[k][0] <= s6_dir1_reg[k] * $signed({1'b0, s6_coef1_reg[LOW-1:0]});
            s7_pp_reg[k][1] <= s6_dir1_reg[k] * $signed(s6_coef1_reg[CW-1:LOW]);
            s7_pp_reg[k][2] <= s6_dir2_reg[k] * $signed({1'b0, s6_coef2_reg[LOW-1:0]});
            s7_pp_reg[k][3] <= s6_dir2_reg[k] * $signed(s6_coef2_reg[CW-1:LOW]);
        end
    end

    // Stage 8: recombine the partial products into the exact numerator.
    ctpt_pkg::region_t      s8_region_reg;
    logic signed [W-1:0]    s8_base_reg [3];
    logic signed [DENW-1:0] s8_den_reg;
    logic signed [NUMW-1:0] s8_num_reg [3];

    always_ff @(posedge clk)
    begin
        s8_region_reg <= s7_region_reg;
        s8_den_reg    <= s7_den_reg;
        for (int k = 0; k < 3; k++)
        begin
            s8_base_reg[k] <= s7_base_reg[k];
            s8_num_reg[k]  <= (NUMW'(s7_pp_reg[k][1]) <<< LOW) + NUMW'(s7_pp_reg[k][0])
                            + (NUMW'(s7_pp_reg[k][3]) <<< LOW) + NUMW'(s7_pp_reg[k][2]);
        end
    end

    // One divider per axis; base and region wait alongside in a delay line.
    logic signed [QW:0] quo [3];

    for (genvar g = 0; g < 3; g++)
    begin : g_axis
        ctpt_divider #(
            .NUM_W (NUMW),
            .DEN_W (DENW),
            .QUO_W (QW)
        ) u_div (
            .clk (clk),
            .num (s8_num_reg[g]),
            .den (s8_den_reg),
            .quo (quo[g])
        );
    end

    ctpt_pkg::region_t   dl_region_reg [DLAT];
    logic signed [W-1:0] dl_base_reg [DLAT][3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DLAT; i++)
        begin
            if (i == 0)
            begin
                dl_region_reg[i] <= s8_region_reg;
                for (int k = 0; k < 3; k++)
                begin
                    dl_base_reg[i][k] <= s8_base_reg[k];
                end
            end
            else
            begin
                dl_region_reg[i] <= dl_region_reg[i-1];
                for (int k = 0; k < 3; k++)
                begin
                    dl_base_reg[i][k] <= dl_base_reg[i-1][k];
                end
            end
        end
    end

    // Final stage: base plus floored quotient, clamped to the coordinate range.
    logic signed [SUMW-1:0] sum_k [3];
    logic signed [W-1:0]    res_next [3];
    logic signed [W-1:0]    res_reg [3];
    ctpt_pkg::region_t      region_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum_k[k] = SUMW'(dl_base_reg[DLAT-1][k]) + SUMW'(quo[k]);
            if (sum_k[k] > SAT_HI)
            begin
                res_next[k] = SAT_HI[W-1:0];
            end
            else if (sum_k[k] < SAT_LO)
            begin
                res_next[k] = SAT_LO[W-1:0];
            end
            else
            begin
                res_next[k] = sum_k[k][W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        region_reg <= dl_region_reg[DLAT-1];
        for (int k = 0; k < 3; k++)
        begin
            res_reg[k] <= res_next[k];
        end
    end

    assign done      = v_reg[TOT-1];
    assign closest_x = res_reg[0];
    assign closest_y = res_reg[1];
    assign closest_z = res_reg[2];
    assign region    = region_reg;

    // Every result strobe traces back to an item that the unit took.
    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result strobe without a matching item");

    // Every item taken leaves the unit as a result strobe.
    a_item_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("item taken but no result strobe after the pipeline latency");

endmodule

`default_nettype wire

/* test/closest_point_on_triangle_unit_test.sv */
// Self-checking testbench for the closest-point-on-triangle unit.
module closest_point_on_triangle_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 16;
    localparam int NUM_RANDOM = 450;
    localparam int TAIL_ITEMS = 60;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT = 300000;

    // Exact intermediate arithmetic. The largest term, a 17-bit edge vector
    // times a 73-bit barycentric weight, fits easily in 128 bits.
    typedef logic signed [127:0] wide_t;
    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec_t;

    typedef struct packed {
        vec_t p;
        vec_t a;
        vec_t b;
        vec_t c;
    } query_t;

    typedef struct packed {
        vec_t              pt;
        ctpt_pkg::region_t reg_code;
    } answer_t;

    // Floor division, as opposed to the truncating operator of the language.
    function automatic wide_t floor_div(wide_t n, wide_t d);
        wide_t q;
        q = n / d;
        if ((n % d != 0) && ((n < 0) != (d < 0)))
            q = q - 1;
        return q;
    endfunction

    function automatic coord_t clamp_coord(wide_t v);
        if (v > wide_t'(32767))
            return coord_t'(32767);
        if (v < -wide_t'(32768))
            return coord_t'(-32768);
        return coord_t'(v);
    endfunction

    function automatic vec_t pack_vec(wide_t w[3]);
        vec_t r;
        r.x = clamp_coord(w[0]);
        r.y = clamp_coord(w[1]);
        r.z = clamp_coord(w[2]);
        return r;
    endfunction

    // Region selection in the order vertex a, vertex b, edge ab, vertex c,
    // edge ac, edge bc, then the degenerate check and the face interior.
    function automatic answer_t closest_on_triangle(query_t q);
        wide_t p[3], a[3], b[3], c[3], ab[3], ac[3], ap[3], bp[3], cp[3], bc[3];
        wide_t r[3];
        wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, e1, e2, den, num;
        answer_t ans;
        p[0] = q.p.x; p[1] = q.p.y; p[2] = q.p.z;
        a[0] = q.a.x; a[1] = q.a.y; a[2] = q.a.z;
        b[0] = q.b.x; b[1] = q.b.y; b[2] = q.b.z;
        c[0] = q.c.x; c[1] = q.c.y; c[2] = q.c.z;
        for (int k = 0; k < 3; k++)
        begin
            ab[k] = b[k] - a[k];
            ac[k] = c[k] - a[k];
            ap[k] = p[k] - a[k];
            bp[k] = p[k] - b[k];
            cp[k] = p[k] - c[k];
            bc[k] = c[k] - b[k];
        end
        d1 = ab[0]*ap[0] + ab[1]*ap[1] + ab[2]*ap[2];
        d2 = ac[0]*ap[0] + ac[1]*ap[1] + ac[2]*ap[2];
        d3 = ab[0]*bp[0] + ab[1]*bp[1] + ab[2]*bp[2];
        d4 = ac[0]*bp[0] + ac[1]*bp[1] + ac[2]*bp[2];
        d5 = ab[0]*cp[0] + ab[1]*cp[1] + ab[2]*cp[2];
        d6 = ac[0]*cp[0] + ac[1]*cp[1] + ac[2]*cp[2];
        vc = d1*d4 - d3*d2;
        vb = d5*d2 - d1*d6;
        va = d3*d6 - d5*d4;
        e1 = d4 - d3;
        e2 = d5 - d6;
        if (d1 <= 0 && d2 <= 0)
        begin
            ans.pt = pack_vec(a);
            ans.reg_code = ctpt_pkg::REG_VERT_A;
        end
        else if (d3 >= 0 && d4 <= d3)
        begin
            ans.pt = pack_vec(b);
            ans.reg_code = ctpt_pkg::REG_VERT_B;
        end
        else if (vc <= 0 && d1 >= 0 && d3 <= 0)
        begin
            // A zero-length edge leaves the start point in place.
            for (int k = 0; k < 3; k++)
                r[k] = (d1 - d3 == 0) ? a[k] : a[k] + floor_div(ab[k]*d1, d1 - d3);
            ans.pt = pack_vec(r);
            ans.reg_code = ctpt_pkg::REG_EDGE_AB;
        end
        else if (d6 >= 0 && d5 <= d6)
        begin
            ans.pt = pack_vec(c);
            ans.reg_code = ctpt_pkg::REG_VERT_C;
        end
        else if (vb <= 0 && d2 >= 0 && d6 <= 0)
        begin
            for (int k = 0; k < 3; k++)
                r[k] = (d2 - d6 == 0) ? a[k] : a[k] + floor_div(ac[k]*d2, d2 - d6);
            ans.pt = pack_vec(r);
            ans.reg_code = ctpt_pkg::REG_EDGE_AC;
        end
        else if (va <= 0 && e1 >= 0 && e2 >= 0)
        begin
            for (int k = 0; k < 3; k++)
                r[k] = (e1 + e2 == 0) ? b[k] : b[k] + floor_div(bc[k]*e1, e1 + e2);
            ans.pt = pack_vec(r);
            ans.reg_code = ctpt_pkg::REG_EDGE_BC;
        end
        else
        begin
            den = va + vb + vc;
            if (den == 0)
            begin
                ans.pt = pack_vec(a);
                ans.reg_code = ctpt_pkg::REG_DEGEN;
            end
            else
            begin
                for (int k = 0; k < 3; k++)
                begin
                    num = ab[k]*vb + ac[k]*vc;
                    r[k] = a[k] + floor_div(num, den);
                end
                ans.pt = pack_vec(r);
                ans.reg_code = ctpt_pkg::REG_FACE;
            end
        end
        return ans;
    endfunction

    // Holds the answers still owed by the unit, oldest first.
    class closest_point_scoreboard;
        answer_t owed[$];
        int      mismatches;

        function void note_query(query_t q);
            owed.push_back(closest_on_triangle(q));
        endfunction

        function void check_answer(answer_t got);
            answer_t want;
            if (owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: %p", got);
                return;
            end
            want = owed.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected (%0d,%0d,%0d) r%0d, got (%0d,%0d,%0d) r%0d",
                             want.pt.x, want.pt.y, want.pt.z, want.reg_code,
                             got.pt.x, got.pt.y, got.pt.z, got.reg_code);
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   start = 1'b0;
    query_t drive_q = '0;
    logic   busy;
    logic   done;
    coord_t closest_x, closest_y, closest_z;
    ctpt_pkg::region_t region;

    closest_point_scoreboard sb = new();
    int cycle_count = 0;

    closest_point_on_triangle_unit #(.COORD_WIDTH(CW)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .point_x   (drive_q.p.x),
        .point_y   (drive_q.p.y),
        .point_z   (drive_q.p.z),
        .vert_a_x  (drive_q.a.x),
        .vert_a_y  (drive_q.a.y),
        .vert_a_z  (drive_q.a.z),
        .vert_b_x  (drive_q.b.x),
        .vert_b_y  (drive_q.b.y),
        .vert_b_z  (drive_q.b.z),
        .vert_c_x  (drive_q.c.x),
        .vert_c_y  (drive_q.c.y),
        .vert_c_z  (drive_q.c.z),
        .done      (done),
        .closest_x (closest_x),
        .closest_y (closest_y),
        .closest_z (closest_z),
        .region    (region)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Both monitors sample at the rising edge, so they see the values that
    // were stable during the cycle that the edge closes.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && start && !busy)
            sb.note_query(drive_q);
        if (rst_n && done)
            sb.check_answer({closest_x, closest_y, closest_z, region});
    end

    // Watchdog against a hang or lost results.
    always @(posedge clk)
    begin
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic vec_t mk_vec(int x, int y, int z);
        vec_t v;
        v.x = coord_t'(x);
        v.y = coord_t'(y);
        v.z = coord_t'(z);
        return v;
    endfunction

    // Holds one item on the inputs until the unit takes it. Start stays high
    // when the caller sends the next item right away.
    task automatic send_query(query_t q);
        start <= 1'b1;
        drive_q <= q;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
    endtask

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 2047)) - coord_t'(1024);
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return coord_t'(-32768);
                    1: return coord_t'(32767);
                    2: return coord_t'(0);
                    3: return coord_t'(-1);
                    default: return coord_t'($urandom);
                endcase
            end
        endcase
    endfunction

    function automatic vec_t rand_vec(int mode);
        return {rand_coord(mode), rand_coord(mode), rand_coord(mode)};
    endfunction

    // Random triangles: mostly general ones, with a share of coincident or
    // collinear vertices so that the edge special cases keep coming up.
    function automatic query_t rand_query();
        query_t q;
        int mode;
        int shape;
        mode = $urandom_range(0, 2);
        q.p = rand_vec(mode);
        q.a = rand_vec(mode);
        q.b = rand_vec(mode);
        q.c = rand_vec(mode);
        shape = $urandom_range(0, 9);
        case (shape)
            0: q.b = q.a;
            1: q.c = q.a;
            2: q.c = q.b;
            3:
            begin
                // Collinear vertices on a small grid.
                q.a = mk_vec(0, 0, 0);
                q.b = mk_vec(256 * $urandom_range(1, 4), 0, 0);
                q.c = mk_vec(256 * $urandom_range(1, 4), 0, 0);
                q.p = rand_vec(1);
            end
            default: ;
        endcase
        return q;
    endfunction

    query_t directed[$];

    initial
    begin
        // Vertex, edge and face regions of one plain triangle.
        directed.push_back({mk_vec(-256, -256, 0), mk_vec(0, 0, 0),
                            mk_vec(1024, 0, 0), mk_vec(0, 1024, 0)});
        directed.push_back({mk_vec(2048, -100, 50), mk_vec(0, 0, 0),
                            mk_vec(1024, 0, 0), mk_vec(0, 1024, 0)});
        directed.push_back({mk_vec(333, -500, 77), mk_vec(0, 0, 0),
                            mk_vec(1024, 0, 0), mk_vec(0, 1024, 0)});
        directed.push_back({mk_vec(-100, 3000, -9), mk_vec(0, 0, 0),
                            mk_vec(1024, 0, 0), mk_vec(0, 1024, 0)});
        directed.push_back({mk_vec(-700, 401, 3), mk_vec(0, 0, 0),
                            mk_vec(1024, 0, 0), mk_vec(0, 1024, 0)});
        directed.push_back({mk_vec(900, 900, -5), mk_vec(0, 0, 0),
                            mk_vec(1024, 0, 0), mk_vec(0, 1024, 0)});
        directed.push_back({mk_vec(301, 211, 999), mk_vec(0, 0, 0),
                            mk_vec(1024, 0, 0), mk_vec(0, 1024, 0)});
        // Negative projections that need flooring.
        directed.push_back({mk_vec(-1, -333, -1), mk_vec(-7, -3, 0),
                            mk_vec(-1000, -5, 1), mk_vec(3, -900, 2)});
        // Zero-length edges and a fully collapsed triangle.
        directed.push_back({mk_vec(128, 0, 0), mk_vec(0, 0, 0),
                            mk_vec(0, 0, 0), mk_vec(256, 0, 0)});
        directed.push_back({mk_vec(50, 60, 70), mk_vec(5, 5, 5),
                            mk_vec(900, 5, 5), mk_vec(5, 5, 5)});
        directed.push_back({mk_vec(10, 20, 30), mk_vec(1, 1, 1),
                            mk_vec(1, 1, 1), mk_vec(1, 1, 1)});
        // Collinear vertices, which can reach the degenerate face.
        directed.push_back({mk_vec(256, 256, 0), mk_vec(0, 0, 0),
                            mk_vec(512, 0, 0), mk_vec(256, 0, 0)});
        directed.push_back({mk_vec(700, -300, 0), mk_vec(0, 0, 0),
                            mk_vec(256, 0, 0), mk_vec(512, 0, 0)});
        // Extremes of every coordinate.
        directed.push_back({mk_vec(32767, 32767, 32767), mk_vec(-32768, -32768, -32768),
                            mk_vec(32767, -32768, 0), mk_vec(-32768, 32767, 32767)});
        directed.push_back({mk_vec(-32768, -32768, -32768), mk_vec(32767, 32767, 32767),
                            mk_vec(-32768, 32767, -32768), mk_vec(32767, -32768, -32768)});
        directed.push_back({mk_vec(0, 0, 0), mk_vec(-32768, -32768, 32767),
                            mk_vec(32767, -32768, -32768), mk_vec(-32768, 32767, -32768)});
        directed.push_back({mk_vec(-1, -1, -1), mk_vec(32767, 0, 0),
                            mk_vec(0, 32767, 0), mk_vec(0, 0, 32767)});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items go in back to back.
        foreach (directed[i])
            send_query(directed[i]);
        start <= 1'b0;

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            // Halfway through, hold off until the pipeline has fully drained.
            if (i == NUM_RANDOM / 2)
            begin
                start <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            if (i < NUM_RANDOM - TAIL_ITEMS && (i / 40) % 2 == 1 && $urandom_range(0, 3) == 0)
                idle_burst();
            send_query(rand_query());
        end
        start <= 1'b0;

        while (sb.pending() != 0 && cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/ctpt_pkg.sv
rtl/core/ctpt_divider.sv
rtl/core/closest_point_on_triangle_unit.sv
test/closest_point_on_triangle_unit_test.sv
